### rtl/core/mwuf_pkg.sv
package mwuf_pkg;

    // Default grid bounds; the top level carries them as parameters.
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    // Fixed field widths.
    localparam int DIM_W     = 6;
    localparam int COORD_W   = 5;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

    // Reset values of the grid registers.
    localparam logic [DIM_W-1:0] RST_GRID_ROWS = 6'd32;
    localparam logic [DIM_W-1:0] RST_GRID_COLS = 6'd32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_LINK,
        ST_GROW,
        ST_FIN
    } t_state;

endpackage

### rtl/core/mwuf_ram.sv
module mwuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mwuf_wall_map.sv
module mwuf_wall_map #(
    parameter int MAX_ROWS = mwuf_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mwuf_pkg::DEF_MAX_COLS,
    parameter int CELL_W   = $clog2(MAX_ROWS * MAX_COLS)
) (
    input  logic [mwuf_pkg::DIM_W-1:0]   i_grid_rows,
    input  logic [mwuf_pkg::DIM_W-1:0]   i_grid_cols,
    input  logic [mwuf_pkg::COORD_W-1:0] i_wall_row,
    input  logic [mwuf_pkg::COORD_W-1:0] i_wall_col,
    input  logic                         i_vertical,
    output logic                         o_ok,
    output logic [CELL_W-1:0]            o_cell_a,
    output logic [CELL_W-1:0]            o_cell_b
);

    localparam int SUM_W = mwuf_pkg::DIM_W + mwuf_pkg::COORD_W + 1;

    logic [mwuf_pkg::DIM_W-1:0]   rows;
    logic [mwuf_pkg::DIM_W-1:0]   cols;
    logic [mwuf_pkg::COORD_W-1:0] base_row;
    logic [mwuf_pkg::COORD_W-1:0] base_col;
    logic [SUM_W-1:0]             sum_a;
    logic [SUM_W-1:0]             sum_b;

    // Saturate the grid size to the supported range.
    always_comb begin
        if (i_grid_rows < 6'd2) begin
            rows = 6'd2;
        end else if (32'(i_grid_rows) > MAX_ROWS) begin
            rows = mwuf_pkg::DIM_W'(MAX_ROWS);
        end else begin
            rows = i_grid_rows;
        end
        if (i_grid_cols < 6'd2) begin
            cols = 6'd2;
        end else if (32'(i_grid_cols) > MAX_COLS) begin
            cols = mwuf_pkg::DIM_W'(MAX_COLS);
        end else begin
            cols = i_grid_cols;
        end
    end

    always_comb begin
        if (i_vertical) begin
            o_ok     = (mwuf_pkg::DIM_W'(i_wall_row) < rows) && (i_wall_col != '0)
                       && (mwuf_pkg::DIM_W'(i_wall_col) < cols);
            base_row = i_wall_row;
            base_col = i_wall_col - 5'd1;
        end else begin
            o_ok     = (i_wall_row != '0) && (mwuf_pkg::DIM_W'(i_wall_row) < rows)
                       && (mwuf_pkg::DIM_W'(i_wall_col) < cols);
            base_row = i_wall_row - 5'd1;
            base_col = i_wall_col;
        end
        // The upper or left cell comes first; its neighbor is one row or one cell on.
        sum_a = SUM_W'(cols) * SUM_W'(base_row) + SUM_W'(base_col);
        sum_b = i_vertical ? sum_a + SUM_W'(1) : sum_a + SUM_W'(cols);
    end

    assign o_cell_a = CELL_W'(sum_a);
    assign o_cell_b = CELL_W'(sum_b);

endmodule

### rtl/core/maze_wall_union_find_unit.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_start_new, i_wall_row, i_wall_col, i_vertical
// output    out        o_out_valid / i_out_stall  o_wall_removed, o_bad_wall
// config    in         i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// An interior wall passes through READ, WALK, LINK, GROW and FIN, skipping GROW when its cells
// already share a root; WALK follows the parent chains from both cells, one memory read per link.
// A bad wall goes straight to FIN. Clearing the forest writes one entry a cycle over all
// MAX_ROWS * MAX_COLS entries: once after reset, input stalled, and ahead of a start_new item.
// A finished result waits in the output register; the next item is taken meanwhile and
// its result is held back until that register is free.
module maze_wall_union_find_unit #(
    parameter int MAX_ROWS = mwuf_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mwuf_pkg::DEF_MAX_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_start_new,
    input  logic [mwuf_pkg::COORD_W-1:0]   i_wall_row,
    input  logic [mwuf_pkg::COORD_W-1:0]   i_wall_col,
    input  logic                           i_vertical,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_wall_removed,
    output logic                           o_bad_wall,
    input  logic                           i_cfg_we,
    input  logic [mwuf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mwuf_pkg::DIM_W-1:0]     i_cfg_wdata
);

    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int SIZE_W     = $clog2(CELL_COUNT + 1);
    localparam int ENTRY_W    = SIZE_W + CELL_W;

    mwuf_pkg::t_state r_state, n_state;

    logic [mwuf_pkg::DIM_W-1:0] r_grid_rows;
    logic [mwuf_pkg::DIM_W-1:0] r_grid_cols;

    logic [CELL_W-1:0] r_clr_cnt, n_clr_cnt;
    logic              r_pend, n_pend;
    logic              r_ok, n_ok;
    logic [CELL_W-1:0] r_cell_a, n_cell_a;
    logic [CELL_W-1:0] r_cell_b, n_cell_b;
    logic [CELL_W-1:0] r_node, n_node;
    logic              r_phase, n_phase;
    logic [CELL_W-1:0] r_root_a, n_root_a;
    logic [CELL_W-1:0] r_root_b, n_root_b;
    logic [SIZE_W-1:0] r_size_a, n_size_a;
    logic [SIZE_W-1:0] r_size_b, n_size_b;
    logic              r_joined, n_joined;
    logic              r_out_valid, n_out_valid;
    logic              r_wall_removed, n_wall_removed;
    logic              r_bad_wall, n_bad_wall;

    logic               wall_ok;
    logic [CELL_W-1:0]  wall_cell_a;
    logic [CELL_W-1:0]  wall_cell_b;

    logic               mem_we;
    logic [CELL_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [CELL_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic [CELL_W-1:0]  rd_parent;
    logic [SIZE_W-1:0]  rd_size;
    logic [CELL_W-1:0]  walk_cell;
    logic               a_wins;
    logic               in_accept;

    mwuf_wall_map #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .CELL_W   (CELL_W)
    ) u_wall_map (
        .i_grid_rows (r_grid_rows),
        .i_grid_cols (r_grid_cols),
        .i_wall_row  (i_wall_row),
        .i_wall_col  (i_wall_col),
        .i_vertical  (i_vertical),
        .o_ok        (wall_ok),
        .o_cell_a    (wall_cell_a),
        .o_cell_b    (wall_cell_b)
    );

    // Each entry holds the set size above the parent link.
    mwuf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELL_COUNT)
    ) u_forest (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_parent = mem_rdata[CELL_W-1:0];
    assign rd_size   = mem_rdata[ENTRY_W-1:CELL_W];
    assign walk_cell = r_phase ? r_cell_b : r_cell_a;
    assign a_wins    = (r_size_a >= r_size_b);
    assign in_accept = i_in_valid && !o_in_stall;

    assign o_in_stall     = (r_state != mwuf_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_wall_removed = r_wall_removed;
    assign o_bad_wall     = r_bad_wall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= mwuf_pkg::RST_GRID_ROWS;
            r_grid_cols <= mwuf_pkg::RST_GRID_COLS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mwuf_pkg::REG_GRID_ROWS: r_grid_rows <= i_cfg_wdata;
                mwuf_pkg::REG_GRID_COLS: r_grid_cols <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mwuf_pkg::ST_CLEAR;
            r_clr_cnt   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok           <= n_ok;
        r_cell_a       <= n_cell_a;
        r_cell_b       <= n_cell_b;
        r_node         <= n_node;
        r_phase        <= n_phase;
        r_root_a       <= n_root_a;
        r_root_b       <= n_root_b;
        r_size_a       <= n_size_a;
        r_size_b       <= n_size_b;
        r_joined       <= n_joined;
        r_wall_removed <= n_wall_removed;
        r_bad_wall     <= n_bad_wall;
    end

    always_comb begin
        n_state        = r_state;
        n_clr_cnt      = r_clr_cnt;
        n_pend         = r_pend;
        n_ok           = r_ok;
        n_cell_a       = r_cell_a;
        n_cell_b       = r_cell_b;
        n_node         = r_node;
        n_phase        = r_phase;
        n_root_a       = r_root_a;
        n_root_b       = r_root_b;
        n_size_a       = r_size_a;
        n_size_b       = r_size_b;
        n_joined       = r_joined;
        n_wall_removed = r_wall_removed;
        n_bad_wall     = r_bad_wall;
        n_out_valid    = r_out_valid && i_out_stall;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            mwuf_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = {SIZE_W'(1), r_clr_cnt};
                n_clr_cnt = r_clr_cnt + CELL_W'(1);
                if (r_clr_cnt == CELL_W'(CELL_COUNT - 1)) begin
                    n_clr_cnt = '0;
                    n_pend    = 1'b0;
                    if (!r_pend) begin
                        n_state = mwuf_pkg::ST_IDLE;
                    end else if (r_ok) begin
                        n_state = mwuf_pkg::ST_READ;
                    end else begin
                        n_state = mwuf_pkg::ST_FIN;
                    end
                end
            end
            mwuf_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_ok     = wall_ok;
                    n_cell_a = wall_cell_a;
                    n_cell_b = wall_cell_b;
                    n_joined = 1'b0;
                    if (i_start_new) begin
                        n_pend  = 1'b1;
                        n_state = mwuf_pkg::ST_CLEAR;
                    end else if (wall_ok) begin
                        n_state = mwuf_pkg::ST_READ;
                    end else begin
                        n_state = mwuf_pkg::ST_FIN;
                    end
                end
            end
            mwuf_pkg::ST_READ: begin
                mem_re    = 1'b1;
                mem_raddr = r_cell_a;
                n_node    = r_cell_a;
                n_phase   = 1'b0;
                n_state   = mwuf_pkg::ST_WALK;
            end
            mwuf_pkg::ST_WALK: begin
                if (rd_parent == r_node) begin
                    // Root reached: point the start cell straight at it.
                    if (r_node != walk_cell) begin
                        mem_we    = 1'b1;
                        mem_waddr = walk_cell;
                        mem_wdata = {SIZE_W'(1), r_node};
                    end
                    if (!r_phase) begin
                        n_root_a  = r_node;
                        n_size_a  = rd_size;
                        n_phase   = 1'b1;
                        n_node    = r_cell_b;
                        mem_re    = 1'b1;
                        mem_raddr = r_cell_b;
                    end else begin
                        n_root_b = r_node;
                        n_size_b = rd_size;
                        n_state  = mwuf_pkg::ST_LINK;
                    end
                end else begin
                    n_node    = rd_parent;
                    mem_re    = 1'b1;
                    mem_raddr = rd_parent;
                end
            end
            mwuf_pkg::ST_LINK: begin
                if (r_root_a == r_root_b) begin
                    n_state = mwuf_pkg::ST_FIN;
                end else begin
                    // The smaller set hangs below the larger; ties go to the first cell.
                    mem_we    = 1'b1;
                    mem_waddr = a_wins ? r_root_b : r_root_a;
                    mem_wdata = a_wins ? {r_size_b, r_root_a} : {r_size_a, r_root_b};
                    n_joined  = 1'b1;
                    n_state   = mwuf_pkg::ST_GROW;
                end
            end
            mwuf_pkg::ST_GROW: begin
                mem_we    = 1'b1;
                mem_waddr = a_wins ? r_root_a : r_root_b;
                mem_wdata = {SIZE_W'(r_size_a + r_size_b), mem_waddr};
                n_state   = mwuf_pkg::ST_FIN;
            end
            mwuf_pkg::ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_wall_removed = r_joined;
                    n_bad_wall     = !r_ok;
                    n_state        = mwuf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mwuf_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_wall_removed && o_bad_wall))
        else $error("wall reported both removed and bad");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < CELL_COUNT))
        else $error("forest write outside the cell range");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mwuf_pkg::ST_WALK) |-> (32'(r_node) < CELL_COUNT))
        else $error("root walk left the cell range");

    a_join_needs_valid_wall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mwuf_pkg::ST_GROW) |-> (r_ok && r_joined && (r_root_a != r_root_b)))
        else $error("union started for an item that cannot join");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int ROWS_MAX = mwuf_pkg::DEF_MAX_ROWS;
    localparam int COLS_MAX = mwuf_pkg::DEF_MAX_COLS;
    localparam int CELLS    = ROWS_MAX * COLS_MAX;
    localparam int CELL_W   = $clog2(CELLS);
    localparam int SIZE_W   = CELL_W + 1;

    typedef struct packed {
        logic removed;
        logic bad;
    } t_wall_verdict;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic                           i_start_new;
    logic [mwuf_pkg::COORD_W-1:0]   i_wall_row;
    logic [mwuf_pkg::COORD_W-1:0]   i_wall_col;
    logic                           i_vertical;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic                           o_wall_removed;
    logic                           o_bad_wall;
    logic                           i_cfg_we;
    logic [mwuf_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mwuf_pkg::DIM_W-1:0]     i_cfg_wdata;

    maze_wall_union_find_unit #(
        .MAX_ROWS(ROWS_MAX),
        .MAX_COLS(COLS_MAX)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_new    (i_start_new),
        .i_wall_row     (i_wall_row),
        .i_wall_col     (i_wall_col),
        .i_vertical     (i_vertical),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_wall_removed (o_wall_removed),
        .o_bad_wall     (o_bad_wall),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the disjoint-set forest and the grid registers.
    logic [CELL_W-1:0]          link_parent [CELLS];
    logic [SIZE_W-1:0]          tree_size   [CELLS];
    logic [mwuf_pkg::DIM_W-1:0] rows_reg = mwuf_pkg::RST_GRID_ROWS;
    logic [mwuf_pkg::DIM_W-1:0] cols_reg = mwuf_pkg::RST_GRID_COLS;

    t_wall_verdict verdicts_due [$];
    int            verdict_errors = 0;
    int            items_sent = 0;
    int            burst_left = 0;

    function automatic void clear_forest();
        for (int i = 0; i < CELLS; i++) begin
            link_parent[i] = CELL_W'(i);
            tree_size[i]   = SIZE_W'(1);
        end
    endfunction

    function automatic int unsigned grid_dim(logic [mwuf_pkg::DIM_W-1:0] v, int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // Walks to the root, then points the start cell straight at it.
    function automatic logic [CELL_W-1:0] root_of(logic [CELL_W-1:0] origin);
        logic [CELL_W-1:0] node;
        node = origin;
        while (link_parent[node] != node) node = link_parent[node];
        link_parent[origin] = node;
        return node;
    endfunction

    function automatic t_wall_verdict carve_wall(logic fresh,
                                                 logic [mwuf_pkg::COORD_W-1:0] row,
                                                 logic [mwuf_pkg::COORD_W-1:0] col,
                                                 logic vert);
        int unsigned       rows, cols, first, second;
        logic [CELL_W-1:0] ra, rb;
        t_wall_verdict     v;
        rows = grid_dim(rows_reg, ROWS_MAX);
        cols = grid_dim(cols_reg, COLS_MAX);
        v = '0;
        if (fresh) clear_forest();
        if (!vert) v.bad = !(row >= 1 && row < rows && col < cols);
        else v.bad = !(row < rows && col >= 1 && col < cols);
        if (v.bad) return v;
        if (!vert) begin
            first  = cols * (row - 1) + col;
            second = first + cols;
        end else begin
            first  = cols * row + col - 1;
            second = first + 1;
        end
        ra = root_of(CELL_W'(first));
        rb = root_of(CELL_W'(second));
        if (ra != rb) begin
            v.removed = 1'b1;
            // Ties go to the upper or left cell's root.
            if (tree_size[ra] >= tree_size[rb]) begin
                tree_size[ra]   = tree_size[ra] + tree_size[rb];
                link_parent[rb] = ra;
            end else begin
                tree_size[rb]   = tree_size[rb] + tree_size[ra];
                link_parent[ra] = rb;
            end
        end
        return v;
    endfunction

    function automatic void pick_interior_wall(output logic [mwuf_pkg::COORD_W-1:0] row,
                                               output logic [mwuf_pkg::COORD_W-1:0] col,
                                               output logic vert);
        int unsigned rows, cols;
        rows = grid_dim(rows_reg, ROWS_MAX);
        cols = grid_dim(cols_reg, COLS_MAX);
        vert = 1'($urandom_range(0, 1));
        if (!vert) begin
            row = mwuf_pkg::COORD_W'($urandom_range(1, rows - 1));
            col = mwuf_pkg::COORD_W'($urandom_range(0, cols - 1));
        end else begin
            row = mwuf_pkg::COORD_W'($urandom_range(0, rows - 1));
            col = mwuf_pkg::COORD_W'($urandom_range(1, cols - 1));
        end
    endfunction

    // Sender: bursts of items with random gaps in between.
    task automatic send_wall(input logic fresh, input logic [mwuf_pkg::COORD_W-1:0] row,
                             input logic [mwuf_pkg::COORD_W-1:0] col, input logic vert);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_start_new <= fresh;
        i_wall_row  <= row;
        i_wall_col  <= col;
        i_vertical  <= vert;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        verdicts_due.insert(verdicts_due.size(), carve_wall(fresh, row, col, vert));
        items_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called while the block is idle.
    task automatic write_grid(input logic [mwuf_pkg::DIM_W-1:0] rows,
                              input logic [mwuf_pkg::DIM_W-1:0] cols);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mwuf_pkg::REG_GRID_ROWS;
        i_cfg_wdata <= rows;
        @(posedge i_clk);
        rows_reg = rows;
        i_cfg_index <= mwuf_pkg::REG_GRID_COLS;
        i_cfg_wdata <= cols;
        @(posedge i_clk);
        cols_reg = cols;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: switches between randomly chosen stall patterns.
    int stall_mode = 0;
    int stall_span = 0;

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 128);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= (stall_span % 4 != 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_wall_verdict want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                $error("unexpected result: wall_removed=%0b bad_wall=%0b",
                       o_wall_removed, o_bad_wall);
                verdict_errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_wall_removed !== want.removed) begin
                    $error("wall_removed: expected %0b, got %0b", want.removed, o_wall_removed);
                    verdict_errors++;
                end
                if (o_bad_wall !== want.bad) begin
                    $error("bad_wall: expected %0b, got %0b", want.bad, o_bad_wall);
                    verdict_errors++;
                end
            end
        end
    end

    // Full 32 by 32 grid straight out of reset.
    task automatic test_reset_grid();
        send_wall(1'b0, 5'd0, 5'd5, 1'b0);
        send_wall(1'b0, 5'd31, 5'd31, 1'b0);
        send_wall(1'b0, 5'd31, 5'd31, 1'b1);
        send_wall(1'b0, 5'd5, 5'd0, 1'b1);
        send_wall(1'b0, 5'd30, 5'd31, 1'b1);
        send_wall(1'b0, 5'd31, 5'd30, 1'b0);
        // Repeats a wall already carved; its cells share a root, so nothing is removed.
        send_wall(1'b0, 5'd31, 5'd31, 1'b0);
        send_wall(1'b0, 5'd0, 5'd0, 1'b1);
        send_wall(1'b0, 5'd1, 5'd0, 1'b0);
        send_wall(1'b1, 5'd31, 5'd31, 1'b0);
        send_wall(1'b0, 5'd0, 5'd31, 1'b1);
        // A fresh maze requested on a bad wall still clears the forest.
        send_wall(1'b1, 5'd0, 5'd0, 1'b0);
        send_wall(1'b0, 5'd0, 5'd31, 1'b1);
    endtask

    task automatic test_grid_extremes();
        wait_drain();
        write_grid(6'd0, 6'd1);
        send_wall(1'b0, 5'd1, 5'd0, 1'b0);
        send_wall(1'b0, 5'd1, 5'd1, 1'b0);
        send_wall(1'b0, 5'd0, 5'd1, 1'b1);
        send_wall(1'b0, 5'd1, 5'd1, 1'b1);
        send_wall(1'b0, 5'd2, 5'd0, 1'b0);
        send_wall(1'b0, 5'd0, 5'd2, 1'b1);
        send_wall(1'b0, 5'd1, 5'd2, 1'b0);
        send_wall(1'b0, 5'd2, 5'd1, 1'b1);
        // Wider stride: old links now connect cells of the top row.
        wait_drain();
        write_grid(6'd63, 6'd33);
        send_wall(1'b0, 5'd0, 5'd1, 1'b1);
        send_wall(1'b0, 5'd31, 5'd31, 1'b0);
    endtask

    // A fresh maze on a small grid clears cells outside it as well.
    task automatic test_fresh_clears_all();
        wait_drain();
        write_grid(6'd2, 6'd2);
        send_wall(1'b1, 5'd1, 5'd0, 1'b0);
        wait_drain();
        write_grid(6'd32, 6'd32);
        send_wall(1'b0, 5'd31, 5'd31, 1'b0);
        send_wall(1'b0, 5'd0, 5'd31, 1'b1);
    endtask

    task automatic test_random_mazes();
        logic [mwuf_pkg::DIM_W-1:0]   new_rows, new_cols;
        logic [mwuf_pkg::COORD_W-1:0] row, col;
        logic                         vert, fresh;
        int                           walls;
        int                           phase;
        phase = 0;
        while (items_sent < 450) begin
            wait_drain();
            case ($urandom_range(0, 5))
                0: begin
                    new_rows = mwuf_pkg::DIM_W'($urandom_range(2, 4));
                    new_cols = mwuf_pkg::DIM_W'($urandom_range(2, 4));
                end
                1, 2: begin
                    new_rows = mwuf_pkg::DIM_W'($urandom_range(2, 8));
                    new_cols = mwuf_pkg::DIM_W'($urandom_range(2, 8));
                end
                3: begin
                    new_rows = mwuf_pkg::DIM_W'($urandom_range(2, 32));
                    new_cols = mwuf_pkg::DIM_W'($urandom_range(2, 32));
                end
                4: begin
                    new_rows = ($urandom_range(0, 1) == 0)
                               ? mwuf_pkg::DIM_W'($urandom_range(0, 1))
                               : mwuf_pkg::DIM_W'($urandom_range(33, 63));
                    new_cols = ($urandom_range(0, 1) == 0)
                               ? mwuf_pkg::DIM_W'($urandom_range(0, 1))
                               : mwuf_pkg::DIM_W'($urandom_range(33, 63));
                end
                default: begin
                    new_rows = 6'd32;
                    new_cols = 6'd32;
                end
            endcase
            write_grid(new_rows, new_cols);
            walls = $urandom_range(20, 70);
            for (int n = 0; n < walls; n++) begin
                // Every fourth phase keeps the forest of the previous grid.
                fresh = (n == 0 && phase % 4 != 3) || ($urandom_range(0, 39) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    row  = mwuf_pkg::COORD_W'($urandom_range(0, 31));
                    col  = mwuf_pkg::COORD_W'($urandom_range(0, 31));
                    vert = 1'($urandom_range(0, 1));
                end else begin
                    pick_interior_wall(row, col, vert);
                end
                send_wall(fresh, row, col, vert);
                if (n == walls / 2 && phase % 3 == 0) wait_drain();
            end
            phase++;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_start_new <= 1'b0;
        i_wall_row  <= '0;
        i_wall_col  <= '0;
        i_vertical  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= mwuf_pkg::REG_GRID_ROWS;
        i_cfg_wdata <= '0;
        clear_forest();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_grid();
        test_grid_extremes();
        test_fresh_clears_all();
        test_random_mazes();
        wait_drain();
        repeat (32) @(posedge i_clk);
        if (verdict_errors == 0 && verdicts_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Worst case is every item clearing the forest, still well under this timeout.
    initial begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### maze_wall_union_find_unit.f
rtl/core/mwuf_pkg.sv
rtl/core/mwuf_ram.sv
rtl/core/mwuf_wall_map.sv
rtl/core/maze_wall_union_find_unit.sv
verif/testbench.sv
